// File: hw/rtl/mbd_pkg.sv
package mbd_pkg;

  localparam int SIZE_W       = 13;    // src_width / src_height register width
  localparam int ROW_W        = 12;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  // register index, taken from paddr[2]
  localparam logic REG_SRC_WIDTH  = 1'b0;
  localparam logic REG_SRC_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       last_pixel;
    logic       level_error;
  } result_t;

  // four 9 bit channel sums of two pixels; lane 0 red .. lane 3 alpha
  typedef logic [3:0][8:0] pair_t;

  function automatic pair_t pack_pair(input pixel_t a, input pixel_t b);
    pair_t r;
    r[0] = 9'(a.red)   + 9'(b.red);
    r[1] = 9'(a.green) + 9'(b.green);
    r[2] = 9'(a.blue)  + 9'(b.blue);
    r[3] = 9'(a.alpha) + 9'(b.alpha);
    return r;
  endfunction

  // floor(x / 4080) = floor(floor(x / 16) / 255); the /255 step is exact
  // for anything below 2^16, and x is at most 1020 * 1020
  function automatic logic [7:0] div_4080(input logic [19:0] x);
    logic [15:0] y;
    logic [15:0] s;
    y = x[19:4];
    s = y + 16'(y >> 8) + 16'd1;
    return s[15:8];
  endfunction

endpackage

// File: hw/rtl/mbd_ram.sv
module mbd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/mipmap_box_downsample.sv
// One mipmap step by a 2x2 box filter over an RGBA stream.
// Source pixels enter on the pixel channel (pixel_valid / pixel_stall) in
// raster order; each output pixel leaves on the result channel once the lower
// right pixel of its quad has been taken. Alpha is the quad alpha sum over
// four, each colour is the colour sum times the alpha sum over 4080, rounded down.
// src_width and src_height are set over the APB port (byte addresses 0 and
// 4); a write also restarts the level at its top left pixel. A 1x1 source
// gives one result per pixel with level_error and last_pixel set.
// One pixel is taken every cycle while pixel_stall is low. The pixel that
// completes a result passes line buffer read, multiply, divide by 4080.
// Even rows are kept as pair sums in a line buffer of MAX_WIDTH/2 words.
// A stall on the result channel holds the final word; the three stages
// close up any bubbles before pixel_stall is raised.
// Reset clears the position, empties the pipeline and sets both sizes to 2;
// the line buffer is not cleared, as every level writes an even row first.
module mipmap_box_downsample #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbd_pkg::PADDR_W-1:0]   paddr,
  input  logic [mbd_pkg::PDATA_W-1:0]   pwdata,
  output logic [mbd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  mbd_pkg::pixel_t               pixel,
  output logic                          result_valid,
  input  logic                          result_stall,
  output mbd_pkg::result_t              result
);
  import mbd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LD = MAX_WIDTH / 2;
  localparam int AW = (LD > 1) ? $clog2(LD) : 1;

  // configuration
  logic [SIZE_W-1:0] src_width;
  logic [SIZE_W-1:0] src_height;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SIZE_W'(2);
      src_height <= SIZE_W'(2);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SRC_WIDTH:  src_width  <= pwdata[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SRC_WIDTH:  prdata = PDATA_W'(src_width);
      REG_SRC_HEIGHT: prdata = PDATA_W'(src_height);
      default:        prdata = '0;
    endcase
  end

  // effective sizes
  logic [WW-1:0]     w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic              w_one, h_one, is_1x1;

  always_comb begin
    if (src_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(src_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(src_width);
    end
    if (src_height == '0) begin
      h_eff = SIZE_W'(1);
    end else if (src_height > SIZE_W'(HEIGHT_LIMIT)) begin
      h_eff = SIZE_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = src_height;
    end
  end

  assign w_one  = (w_eff == WW'(1));
  assign h_one  = (h_eff == SIZE_W'(1));
  assign is_1x1 = w_one & h_one;

  // handshake
  logic en1, en2, en3, accept;
  logic v1, v2, v3;

  assign en3         = ~v3 | ~result_stall;
  assign en2         = ~v2 | en3;
  assign en1         = ~v1 | en2;
  assign pixel_stall = ~en1;
  assign accept      = pixel_valid & en1;

  // raster position
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic             col_last, row_last;

  assign col_last = (WW'(col) == w_eff - WW'(1));
  assign row_last = (SIZE_W'(row) == h_eff - SIZE_W'(1));

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_last) begin
        col <= '0;
        row <= row_last ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // pair forming and quad selection
  pixel_t            held_pixel;
  pair_t             pair_in;
  logic              have_pair, quad_hit, last_in, ram_we;
  logic [AW-1:0]     p;
  logic [WW-1:0]     out_w;
  logic [ROW_W-1:0]  out_row;
  logic [SIZE_W-1:0] out_h;

  always_ff @(posedge clk) begin
    if (accept && !col[0]) begin
      held_pixel <= pixel;
    end
  end

  assign pair_in   = pack_pair(w_one ? pixel : held_pixel, pixel);
  assign have_pair = w_one | col[0];
  assign p         = w_one ? '0 : AW'(col >> 1);
  assign quad_hit  = have_pair & (h_one | row[0]);
  assign ram_we    = accept & ~is_1x1 & have_pair & ~h_one & ~row[0];

  assign out_w   = w_one ? WW'(1) : (w_eff >> 1);
  assign out_row = h_one ? '0 : (row >> 1);
  assign out_h   = h_one ? SIZE_W'(1) : (h_eff >> 1);
  assign last_in = (WW'(p) == out_w - WW'(1))
                && (SIZE_W'(out_row) == out_h - SIZE_W'(1));

  // line buffer of even-row pair sums
  pair_t ram_q;

  mbd_ram #(
    .WIDTH ($bits(pair_t)),
    .DEPTH (LD)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p),
    .wdata (pair_in),
    .re    (en1),
    .raddr (p),
    .rdata (ram_q)
  );

  // stage 1: pair and line buffer word
  logic  err1, last1, sel1;
  pair_t pair1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept & (is_1x1 | quad_hit);
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      err1  <= is_1x1;
      last1 <= is_1x1 | last_in;
      sel1  <= ~is_1x1 & ~h_one;
      pair1 <= is_1x1 ? '0 : pair_in;   // error word comes out all zero
    end
  end

  // stage 2: quad sums and alpha weighting
  pair_t            quad_a;
  logic [9:0]       asum;
  logic [2:0][9:0]  csum;
  logic [2:0][19:0] prod2;
  logic [7:0]       alpha2;
  logic             err2, last2;

  always_comb begin
    quad_a = sel1 ? ram_q : pair1;
    asum   = 10'(quad_a[3]) + 10'(pair1[3]);
    for (int c = 0; c < 3; c++) begin
      csum[c] = 10'(quad_a[c]) + 10'(pair1[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int c = 0; c < 3; c++) begin
        prod2[c] <= 20'(csum[c]) * 20'(asum);
      end
      alpha2 <= 8'(asum >> 2);
      err2   <= err1;
      last2  <= last1;
    end
  end

  // stage 3: divide by 4080 into the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      result.out_red     <= div_4080(prod2[0]);
      result.out_green   <= div_4080(prod2[1]);
      result.out_blue    <= div_4080(prod2[2]);
      result.out_alpha   <= alpha2;
      result.last_pixel  <= last2;
      result.level_error <= err2;
    end
  end

  assign result_valid = v3;

endmodule

// File: hw/rtl/mbd_checker.sv
module mbd_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input mbd_pkg::result_t result
);
  import mbd_pkg::*;

  // nothing can be in flight on the cycle after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result word right after reset");

  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result word dropped under stall");

  a_word_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result word changed under stall");

  a_error_word: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.level_error |->
      result.last_pixel && result.out_red == 8'd0 && result.out_green == 8'd0
      && result.out_blue == 8'd0 && result.out_alpha == 8'd0)
    else $error("level error word not blank");

  // alpha sum below four weights every colour to zero
  a_clear_quad: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.out_alpha == 8'd0 |->
      result.out_red == 8'd0 && result.out_green == 8'd0 && result.out_blue == 8'd0)
    else $error("colour from fully transparent quad");

endmodule

bind mipmap_box_downsample mbd_checker u_checker (.*);
